// File: hdl/ple_pkg.sv
// Package for the positional list engine: command, status and cell control types.
// No dependencies; used by ple_cell, positional_list_engine_core and the testbench.
package ple_pkg;

  // widest cell position (CAPACITY is at most 256)
  localparam int unsigned POS_W = 8;

  typedef enum logic [3:0] {
    OP_ADD_FIRST = 4'd0,
    OP_ADD_LAST  = 4'd1,
    OP_INSERT    = 4'd2,
    OP_RM_FIRST  = 4'd3,
    OP_RM_LAST   = 4'd4,
    OP_RM_AT     = 4'd5,
    OP_RM_VAL    = 4'd6,
    OP_GET       = 4'd7,
    OP_SET_AT    = 4'd8,
    OP_REPL_VAL  = 4'd9,
    OP_FIND      = 4'd10,
    OP_COUNT     = 4'd11,
    OP_SUM       = 4'd12,
    OP_CLEAR     = 4'd13
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_RANGE     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // what every cell does in a cycle
  typedef enum logic [2:0] {
    CM_HOLD,
    CM_INSERT,
    CM_DELETE,
    CM_ROTATE,
    CM_SWAP
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e       mode;
    logic [POS_W-1:0] pos;    // insert or delete position
    logic             phase;  // odd/even pairing for compaction passes
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_ROTATE,
    FSM_COMPACT
  } fsm_e;

endpackage

// File: hdl/ple_cell.sv
// One list cell: holds one entry and a removal mark, trades with its neighbours.
// Depends on ple_pkg.
module ple_cell import ple_pkg::*; #(
  parameter int unsigned IDX        = 0,
  parameter bit          LAST       = 1'b0,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [DATA_WIDTH-1:0] load_i,
  input  logic [DATA_WIDTH-1:0] lo_data_i,
  input  logic                  lo_dead_i,
  input  logic [DATA_WIDTH-1:0] hi_data_i,
  input  logic                  hi_dead_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  dead_o
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);
  localparam logic             MY_ODD = 1'(IDX % 2);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  dead_q, dead_d;

  // neighbour selection
  always_comb begin
    data_d = data_q;
    dead_d = dead_q;
    unique case (ctrl_i.mode)
      CM_INSERT: begin
        if (MY_POS > ctrl_i.pos) begin
          data_d = lo_data_i;
          dead_d = lo_dead_i;
        end else if (MY_POS == ctrl_i.pos) begin
          data_d = load_i;
          dead_d = 1'b0;
        end
      end
      CM_DELETE: begin
        if (MY_POS >= ctrl_i.pos) begin
          data_d = hi_data_i;
          dead_d = hi_dead_i;
        end
      end
      CM_ROTATE: begin
        data_d = hi_data_i;
        dead_d = hi_dead_i;
      end
      CM_SWAP: begin
        // marked entries bubble upwards past live ones
        if (MY_ODD == ctrl_i.phase) begin
          if (!LAST && dead_q && !hi_dead_i) begin
            data_d = hi_data_i;
            dead_d = hi_dead_i;
          end
        end else if (IDX != 0 && lo_dead_i && !dead_q) begin
          data_d = lo_data_i;
          dead_d = lo_dead_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    dead_q <= dead_d;
  end

  assign data_o = data_q;
  assign dead_o = dead_q;

endmodule

// File: hdl/positional_list_engine_core.sv
// Top level of the positional list engine: command decode, sequencer and cell row.
// Depends on ple_pkg and ple_cell.
//
// Takes one command when start_i is high and busy_o is low; its result shows on
// the result ports for one cycle with done_o high, in the cycle after the last
// working cycle, and cannot be held off. Add, insert, remove at a position,
// clear, unused codes and refused get, set and sum are done straight from idle,
// all cells shifting at once. Find, count, replace, remove by value and accepted
// get, set and sum rotate the whole row of cells through cell 0 once. Remove by
// value that finds a match then runs CAPACITY odd/even compaction passes. Cell
// contents are not cleared at reset; only the entry count, the state and the
// done flag are.
module positional_list_engine_core import ple_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [3:0]         operation_i,
  input  logic [4:0]         index_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] old_value_i,
  output logic               done_o,
  output logic signed [31:0] read_value_o,
  output logic               found_o,
  output logic [4:0]         match_count_o,
  output logic [4:0]         entry_count_o,
  output logic [2:0]         status_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned XW = (CW > 5) ? CW : 5;
  localparam logic [SW-1:0] LAST_STEP = SW'(CAPACITY - 1);

  // cell row
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic                  cell_dead [CAPACITY];
  logic [DATA_WIDTH-1:0] wrap_data;
  logic                  wrap_dead;
  logic [DATA_WIDTH-1:0] load_data;
  cell_ctrl_t            ctrl;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ple_cell #(
      .IDX        (i),
      .LAST       (i == CAPACITY - 1),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .load_i    (load_data),
      .lo_data_i ((i == 0) ? load_data : cell_data[(i == 0) ? 0 : i - 1]),
      .lo_dead_i ((i == 0) ? 1'b0 : cell_dead[(i == 0) ? 0 : i - 1]),
      .hi_data_i ((i == CAPACITY - 1) ? wrap_data : cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .hi_dead_i ((i == CAPACITY - 1) ? wrap_dead : cell_dead[(i == CAPACITY - 1) ? i : i + 1]),
      .data_o    (cell_data[i]),
      .dead_o    (cell_dead[i])
    );
  end

  // control and result registers
  fsm_e                  state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [SW-1:0]         step_q, step_d;
  op_e                   op_q, op_d;
  logic [XW-1:0]         idx_q, idx_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic [CW-1:0]         mcnt_q, mcnt_d;
  logic                  done_q, done_d;
  logic [DATA_WIDTH-1:0] rd_q, rd_d;
  logic                  found_q, found_d;
  logic [CW-1:0]         mc_q, mc_d;
  status_e               status_q, status_d;

  logic [XW-1:0]         cnt_x, in_idx, pos_x;
  logic [DATA_WIDTH-1:0] in_val, in_old;
  logic                  in_range, hit;
  logic [CW-1:0]         n_fin;
  op_e                   in_op;

  assign cnt_x    = XW'(cnt_q);
  assign in_idx   = XW'(index_i);
  assign in_val   = DATA_WIDTH'(value_i);
  assign in_old   = DATA_WIDTH'(old_value_i);
  assign in_op    = op_e'(operation_i);
  assign in_range = XW'(step_q) < cnt_x;
  assign hit      = (cell_data[0] == key_q) && in_range;
  assign n_fin    = mcnt_q + CW'(hit);
  assign load_data = (state_q == FSM_IDLE) ? in_val : val_q;

  // sequencer: next state, cell control and results
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    step_d   = step_q;
    op_d     = op_q;
    idx_d    = idx_q;
    key_d    = key_q;
    val_d    = val_q;
    acc_d    = acc_q;
    mcnt_d   = mcnt_q;
    done_d   = 1'b0;
    rd_d     = rd_q;
    found_d  = found_q;
    mc_d     = mc_q;
    status_d = status_q;
    ctrl     = '{mode: CM_HOLD, pos: '0, phase: 1'b0};
    pos_x    = '0;
    wrap_data = cell_data[0];
    wrap_dead = 1'b0;

    unique case (state_q)
      FSM_IDLE: begin
        if (start_i) begin
          done_d   = 1'b1;
          rd_d     = '0;
          found_d  = 1'b0;
          mc_d     = '0;
          status_d = ST_OK;
          op_d     = in_op;
          idx_d    = in_idx;
          val_d    = in_val;
          key_d    = (in_op == OP_REPL_VAL) ? in_old : in_val;
          acc_d    = '0;
          mcnt_d   = '0;
          step_d   = '0;
          unique case (in_op)
            OP_ADD_FIRST, OP_ADD_LAST, OP_INSERT: begin
              pos_x = (in_op == OP_ADD_FIRST) ? '0 :
                      (in_op == OP_ADD_LAST) ? cnt_x : in_idx;
              if (pos_x > cnt_x) begin
                status_d = ST_RANGE;
              end else if (cnt_x >= XW'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                ctrl  = '{mode: CM_INSERT, pos: POS_W'(pos_x), phase: 1'b0};
                cnt_d = cnt_q + 1'b1;
              end
            end
            OP_RM_FIRST, OP_RM_LAST, OP_RM_AT: begin
              pos_x = (in_op == OP_RM_FIRST) ? '0 :
                      (in_op == OP_RM_LAST) ? cnt_x - 1'b1 : in_idx;
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                ctrl  = '{mode: CM_DELETE, pos: POS_W'(pos_x), phase: 1'b0};
                cnt_d = cnt_q - 1'b1;
              end
            end
            OP_GET, OP_SET_AT: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else if (in_idx >= cnt_x) begin
                status_d = ST_RANGE;
              end else begin
                done_d  = 1'b0;
                state_d = FSM_ROTATE;
              end
            end
            OP_SUM: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                done_d  = 1'b0;
                state_d = FSM_ROTATE;
              end
            end
            OP_RM_VAL, OP_REPL_VAL, OP_FIND, OP_COUNT: begin
              done_d  = 1'b0;
              state_d = FSM_ROTATE;
            end
            OP_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end

      FSM_ROTATE: begin
        // cell 0 leaves the row and re-enters at the top
        ctrl = '{mode: CM_ROTATE, pos: '0, phase: 1'b0};
        if (((op_q == OP_REPL_VAL) && hit) ||
            ((op_q == OP_SET_AT) && (XW'(step_q) == idx_q))) begin
          wrap_data = val_q;
        end
        wrap_dead = (op_q == OP_RM_VAL) && hit;
        if (in_range) acc_d = acc_q + cell_data[0];
        mcnt_d = n_fin;
        if ((op_q == OP_GET) && (XW'(step_q) == idx_q)) rd_d = cell_data[0];
        step_d = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          step_d = '0;
          if (op_q == OP_SUM) rd_d = acc_d;
          if ((op_q == OP_RM_VAL) || (op_q == OP_REPL_VAL) ||
              (op_q == OP_FIND) || (op_q == OP_COUNT)) begin
            found_d = n_fin != '0;
            mc_d    = n_fin;
          end
          priority if (op_q == OP_RM_VAL && cnt_q == '0) begin
            status_d = ST_EMPTY;
          end else if ((op_q == OP_RM_VAL || op_q == OP_REPL_VAL) && n_fin == '0) begin
            status_d = ST_NOT_FOUND;
          end else if (op_q == OP_RM_VAL) begin
            status_d = ST_OK;
          end else begin
            status_d = ST_OK;
          end
          if (op_q == OP_RM_VAL && cnt_q != '0 && n_fin != '0) begin
            state_d = FSM_COMPACT;
          end else begin
            state_d = FSM_IDLE;
            done_d  = 1'b1;
          end
        end
      end

      FSM_COMPACT: begin
        // one odd/even exchange pass per cycle
        ctrl   = '{mode: CM_SWAP, pos: '0, phase: step_q[0]};
        step_d = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          cnt_d   = cnt_q - mc_q;
          state_d = FSM_IDLE;
          done_d  = 1'b1;
        end
      end

      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    op_q     <= op_d;
    idx_q    <= idx_d;
    key_q    <= key_d;
    val_q    <= val_d;
    acc_q    <= acc_d;
    mcnt_q   <= mcnt_d;
    rd_q     <= rd_d;
    found_q  <= found_d;
    mc_q     <= mc_d;
    status_q <= status_d;
  end

  assign busy_o        = state_q != FSM_IDLE;
  assign done_o        = done_q;
  assign read_value_o  = 32'(rd_q);
  assign found_o       = found_q;
  assign match_count_o = 5'(mc_q);
  assign entry_count_o = 5'(cnt_q);
  assign status_o      = status_q;

endmodule

// File: tb/testbench.sv
// Testbench for positional_list_engine_core: directed command table, a fill to capacity, then random commands.
// Depends on ple_pkg and the engine RTL; results are checked against a list predictor.
module testbench;
  import ple_pkg::*;

  localparam int unsigned CAP = 16;

  typedef struct packed {
    logic [3:0]         op;
    logic [4:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] old;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] rd;
    logic               fnd;
    logic [4:0]         mc;
    logic [4:0]         cnt;
    logic [2:0]         st;
  } res_t;

  // directed row: command, whether a typed-in result applies, and that result
  typedef struct packed {
    cmd_t cmd;
    logic fixed;
    res_t res;
  } row_t;

  logic               clk_i, rst_ni, start_i, busy_o, done_o, found_o;
  logic [3:0]         operation_i;
  logic [4:0]         index_i;
  logic signed [31:0] value_i, old_value_i, read_value_o;
  logic [4:0]         match_count_o, entry_count_o;
  logic [2:0]         status_o;

  positional_list_engine_core dut (.*);

  // predictor state
  logic [31:0] list_q [$];
  res_t        pending_q [$];
  int          fails;
  int          idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("** positional_list_engine_core: FAILED **");
    $finish;
  end

  function automatic int unsigned key_hits(logic [31:0] k);
    int unsigned n = 0;
    foreach (list_q[i]) if (list_q[i] == k) n++;
    return n;
  endfunction

  // work out the result of one command and update the list copy
  function automatic res_t list_apply(cmd_t c);
    res_t r = '0;
    int unsigned n = list_q.size();
    int unsigned p = c.idx;
    case (c.op)
      OP_ADD_FIRST, OP_ADD_LAST, OP_INSERT: begin
        if (c.op == OP_ADD_FIRST) p = 0;
        else if (c.op == OP_ADD_LAST) p = n;
        if (p > n) r.st = ST_RANGE;
        else if (n >= CAP) r.st = ST_FULL;
        else list_q.insert(p, c.val);
      end
      OP_RM_FIRST, OP_RM_LAST, OP_RM_AT: begin
        if (n == 0) r.st = ST_EMPTY;
        else begin
          if (c.op == OP_RM_FIRST) p = 0;
          else if (c.op == OP_RM_LAST) p = n - 1;
          if (p >= n) r.st = ST_RANGE;
          else list_q.delete(p);
        end
      end
      OP_RM_VAL: begin
        r.mc = 5'(key_hits(c.val));
        r.fnd = r.mc != 0;
        if (n == 0) r.st = ST_EMPTY;
        else if (r.mc == 0) r.st = ST_NOT_FOUND;
        else for (int i = n - 1; i >= 0; i--) if (list_q[i] == c.val) list_q.delete(i);
      end
      OP_GET, OP_SET_AT: begin
        if (n == 0) r.st = ST_EMPTY;
        else if (p >= n) r.st = ST_RANGE;
        else if (c.op == OP_GET) r.rd = list_q[p];
        else list_q[p] = c.val;
      end
      OP_REPL_VAL: begin
        r.mc = 5'(key_hits(c.old));
        r.fnd = r.mc != 0;
        if (r.mc == 0) r.st = ST_NOT_FOUND;
        else foreach (list_q[i]) if (list_q[i] == c.old) list_q[i] = c.val;
      end
      OP_FIND, OP_COUNT: begin
        r.mc = 5'(key_hits(c.val));
        r.fnd = r.mc != 0;
      end
      OP_SUM: begin
        if (n == 0) r.st = ST_EMPTY;
        else foreach (list_q[i]) r.rd += list_q[i];
      end
      OP_CLEAR: list_q.delete();
      default: ;
    endcase
    r.cnt = 5'(list_q.size());
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && done_o) begin
      got = '{read_value_o, found_o, match_count_o, entry_count_o, status_o};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fails++;
      end else begin
        want = pending_q.pop_front();
        if (got.rd !== want.rd) begin
          $display("%0t: read_value exp %h got %h", $time, want.rd, got.rd); fails++;
        end
        if (got.fnd !== want.fnd) begin
          $display("%0t: found exp %b got %b", $time, want.fnd, got.fnd); fails++;
        end
        if (got.mc !== want.mc) begin
          $display("%0t: match_count exp %0d got %0d", $time, want.mc, got.mc); fails++;
        end
        if (got.cnt !== want.cnt) begin
          $display("%0t: entry_count exp %0d got %0d", $time, want.cnt, got.cnt); fails++;
        end
        if (got.st !== want.st) begin
          $display("%0t: status exp %0d got %0d", $time, want.st, got.st); fails++;
        end
      end
    end
  end

  // drive one item; start stays high across back-to-back items
  task automatic send_item(cmd_t c, logic fixed, res_t fixed_res);
    res_t r;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i     <= 1'b1;
    operation_i <= c.op;
    index_i     <= c.idx;
    value_i     <= c.val;
    old_value_i <= c.old;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    r = list_apply(c);
    if (fixed && r !== fixed_res) begin
      $display("%0t: table row exp %h predictor %h", $time, fixed_res, r);
      fails++;
    end
    pending_q.push_back(r);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    // mostly a small pool so keys hit, sometimes the extremes or anything
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(5) - 2;
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int unsigned n = list_q.size();
    c.op  = $urandom_range(99) < 3 ? 4'($urandom_range(15)) : 4'($urandom_range(OP_SUM));
    // keep the list filling and draining: adds more likely when short
    if ($urandom_range(CAP) >= n && $urandom_range(2) == 0)
      c.op = 4'($urandom_range(OP_INSERT));
    else if ($urandom_range(50) == 0)
      c.op = OP_CLEAR;
    c.idx = $urandom_range(9) == 0 ? 5'($urandom_range(31)) : 5'($urandom_range(n + 1));
    c.val = pick_value();
    c.old = (n != 0 && $urandom_range(1)) ? list_q[$urandom_range(n - 1)] : pick_value();
    return c;
  endfunction

  row_t table_rows [] = '{
    '{'{OP_SUM,      5'd0,  32'sd0, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, 5'd0, ST_EMPTY}},
    '{'{OP_RM_FIRST, 5'd0,  32'sd0, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, 5'd0, ST_EMPTY}},
    '{'{OP_RM_VAL,   5'd0,  32'sd1, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, 5'd0, ST_EMPTY}},
    '{'{OP_GET,      5'd0,  32'sd0, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, 5'd0, ST_EMPTY}},
    '{'{OP_INSERT,   5'd1,  32'sd5, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, 5'd0, ST_RANGE}},
    '{'{OP_ADD_LAST, 5'd0,  32'h7fffffff, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, 5'd1, ST_OK}},
    '{'{OP_ADD_FIRST,5'd0,  32'h80000000, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, 5'd2, ST_OK}},
    '{'{OP_SUM,      5'd0,  32'sd0, 32'sd0}, 1'b1, '{32'hffffffff, 1'b0, 5'd0, 5'd2, ST_OK}},
    '{'{OP_INSERT,   5'd2,  32'sd7, 32'sd0}, 1'b0, '0},
    '{'{OP_GET,      5'd31, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, 5'd3, ST_RANGE}},
    '{'{OP_SET_AT,   5'd1,  32'sd7, 32'sd0}, 1'b0, '0},
    '{'{OP_FIND,     5'd0,  32'sd7, 32'sd0}, 1'b0, '0},
    '{'{OP_COUNT,    5'd0,  32'sd9, 32'sd0}, 1'b0, '0},
    '{'{OP_REPL_VAL, 5'd0,  32'sd9, 32'sd7}, 1'b0, '0},
    '{'{OP_REPL_VAL, 5'd0,  32'sd1, 32'sd3}, 1'b0, '0},
    '{'{OP_RM_VAL,   5'd0,  32'sd9, 32'sd0}, 1'b0, '0},
    '{'{OP_RM_VAL,   5'd0,  32'sd4, 32'sd0}, 1'b0, '0},
    '{'{OP_RM_AT,    5'd5,  32'sd0, 32'sd0}, 1'b0, '0},
    '{'{OP_RM_LAST,  5'd0,  32'sd0, 32'sd0}, 1'b0, '0},
    '{'{4'd14,       5'd0,  32'sd0, 32'sd0}, 1'b0, '0},
    '{'{4'd15,       5'd31, 32'hffffffff, 32'hffffffff}, 1'b0, '0},
    '{'{OP_CLEAR,    5'd0,  32'sd0, 32'sd0}, 1'b1, '{32'sd0, 1'b0, 5'd0, 5'd0, ST_OK}}
  };

  initial begin
    cmd_t c;
    int   waited;
    fails = 0;
    idle_pct = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    operation_i = '0;
    index_i = '0;
    value_i = '0;
    old_value_i = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (table_rows[i]) send_item(table_rows[i].cmd, table_rows[i].fixed,
                                      table_rows[i].res);
    // fill to capacity, then a refused insert at the count on a full list and an out-of-range get
    for (int i = 0; i < CAP; i++) begin
      c = '{OP_ADD_LAST, 5'd0, $urandom(), 32'sd0};
      send_item(c, 1'b0, '0);
    end
    send_item('{OP_INSERT, 5'd16, 32'sd1, 32'sd0}, 1'b1,
              '{32'sd0, 1'b0, 5'd0, 5'd16, ST_FULL});
    send_item('{OP_GET, 5'd16, 32'sd0, 32'sd0}, 1'b1,
              '{32'sd0, 1'b0, 5'd0, 5'd16, ST_RANGE});
    // random part in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = ph == 0 ? 17 : (ph == 1 ? 66 : 0);
      repeat (380) send_item(rand_cmd(), 1'b0, '0);
    end
    start_i <= 1'b0;
    waited = 0;
    while (pending_q.size() != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4 * CAP) @(posedge clk_i);
    if (fails == 0 && pending_q.size() == 0)
      $display("** positional_list_engine_core: PASSED **");
    else
      $display("** positional_list_engine_core: FAILED **");
    $finish;
  end

endmodule

// File: positional_list_engine_core.f
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine_core.sv
tb/testbench.sv
